FILE: design/pie_pkg.sv
`timescale 1ns / 1ps
package pie_pkg;

    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned ID_W       = 10;
    localparam int unsigned NCNT_W     = 11;
    localparam int unsigned ITER_W     = 16;
    localparam int unsigned DAMP_W     = 16;
    localparam int unsigned EPS_W      = 32;
    localparam int unsigned RANK_OUT_W = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef logic [FUNC_W-1:0]    t_func;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_func FUNC_ADD  = 2'd0;
    localparam t_func FUNC_RUN  = 2'd1;
    localparam t_func FUNC_READ = 2'd2;
    localparam t_func FUNC_NONE = 2'd3;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BAD_ID = 2'd1;
    localparam t_status ST_FULL   = 2'd2;

    localparam t_cfg_idx REG_NODE_COUNT = 2'd0;
    localparam t_cfg_idx REG_MAX_ITER   = 2'd1;
    localparam t_cfg_idx REG_DAMPING    = 2'd2;
    localparam t_cfg_idx REG_EPSILON    = 2'd3;

    localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 11'd1024;
    localparam logic [ITER_W-1:0] MAX_ITER_RST   = 16'd100;
    localparam logic [DAMP_W-1:0] DAMPING_RST    = 16'd55706;
    localparam logic [EPS_W-1:0]  EPSILON_RST    = 32'd21475;

endpackage

FILE: design/pie_cmd_if.sv
`timescale 1ns / 1ps
interface pie_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [pie_pkg::FUNC_W-1:0]     func;
    logic [pie_pkg::ID_W-1:0]       edge_from;
    logic [pie_pkg::ID_W-1:0]       edge_to;
    logic [pie_pkg::ID_W-1:0]       read_node;

    modport source (output valid, func, edge_from, edge_to, read_node, input ready);
    modport sink   (input valid, func, edge_from, edge_to, read_node, output ready);
endinterface

FILE: design/pie_rsp_if.sv
`timescale 1ns / 1ps
interface pie_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [pie_pkg::RANK_OUT_W-1:0]   rank_value;
    logic [pie_pkg::ITER_W-1:0]       iterations_done;
    logic [pie_pkg::STATUS_W-1:0]     status;

    modport source (output valid, rank_value, iterations_done, status, input ready);
    modport sink   (input valid, rank_value, iterations_done, status, output ready);
endinterface

FILE: design/pagerank_iteration_engine_core.sv
`timescale 1ns / 1ps
// Add edge runs via S_ADD_WR and read via S_READ to S_DONE; an unused func gives no beat.
// Run: setup divides for start rank and base term, an init pass over the N nodes, then per
// pass the E stored edges (each live one through the serial divider) and a node update;
// then sum and normalize passes. One item is in work at a time; a result may wait while
// the next is taken. Reset is synchronous; then an out-degree clearing pass over MAX_NODES
// entries runs before the first item is accepted. Config resets to its documented defaults.
module pagerank_iteration_engine_core #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096,
    parameter int RANK_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pie_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pie_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pie_cmd_if.sink                       i_cmd,
    pie_rsp_if.source                     o_rsp
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int VW   = (ECW > CW) ? ECW : CW;
    localparam int FB   = RANK_BITS - 1;
    localparam int DCW  = $clog2(RANK_BITS + 1);
    localparam int SW   = RANK_BITS + CW;
    localparam int AW   = 63;
    localparam int BDW  = 17 + RANK_BITS;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_ADD_WR, S_READ, S_DIV, S_RUN_BASE, S_INIT,
        S_E_RD, S_E_CHK, S_E_DIV, S_E_ACC_RD, S_E_ACC_WR,
        S_N_RD, S_N_MUL, S_N_WR, S_S_RD, S_S_ADD,
        S_Q_RD, S_Q_INIT, S_Q_STEP, S_DONE
    } t_state;

    // configuration
    logic [pie_pkg::NCNT_W-1:0] r_node_count;
    logic [pie_pkg::ITER_W-1:0] r_max_iter;
    logic [pie_pkg::DAMP_W-1:0] r_damp;
    logic [pie_pkg::EPS_W-1:0]  r_eps;

    // control and datapath registers
    t_state               r_state, n_state, r_ret, n_ret;
    logic [CW-1:0]        r_i, n_i;
    logic [ECW-1:0]       r_e, n_e, r_edges, n_edges;
    logic [NW-1:0]        r_f, n_f, r_t, n_t;
    logic [RANK_BITS-1:0] r_start, n_start, r_base, n_base;
    logic [RANK_BITS-1:0] r_dq, n_dq;
    logic [VW-1:0]        r_dr, n_dr, r_dv, n_dv;
    logic [DCW-1:0]       r_cnt, n_cnt;
    logic [pie_pkg::ITER_W-1:0] r_iter, n_iter;
    logic                 r_more, n_more;
    logic [AW-17:0]       r_ph, n_ph;
    logic [31:0]          r_pl, n_pl;
    logic [RANK_BITS-1:0] r_old, n_old;
    logic [SW-1:0]        r_sum, n_sum, r_qr, n_qr;
    logic [RANK_BITS-1:0] r_qq, n_qq;
    logic [RANK_BITS-1:0] r_res_rank, n_res_rank;
    logic [pie_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic [pie_pkg::RANK_OUT_W-1:0] r_out_rank, n_out_rank;
    logic [pie_pkg::ITER_W-1:0]     r_out_iter, n_out_iter;
    logic [pie_pkg::STATUS_W-1:0]   r_out_status, n_out_status;

    // memories
    logic [2*NW-1:0]      edge_mem [MAX_EDGES];
    logic [ECW-1:0]       deg_mem  [MAX_NODES];
    logic [RANK_BITS-1:0] rank_mem [MAX_NODES];
    logic [AW-1:0]        acc_mem  [MAX_NODES];

    logic                 edge_we, deg_we, rank_we, acc_we;
    logic [EAW-1:0]       edge_wa, edge_ra;
    logic [2*NW-1:0]      edge_wd, edge_rd;
    logic [NW-1:0]        deg_wa, deg_ra, rank_wa, rank_ra, acc_wa, acc_ra;
    logic [ECW-1:0]       deg_wd, deg_rd;
    logic [RANK_BITS-1:0] rank_wd, rank_rd;
    logic [AW-1:0]        acc_wd, acc_rd;

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[edge_wa] <= edge_wd;
        end
        edge_rd <= edge_mem[edge_ra];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            deg_mem[deg_wa] <= deg_wd;
        end
        deg_rd <= deg_mem[deg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            rank_mem[rank_wa] <= rank_wd;
        end
        rank_rd <= rank_mem[rank_ra];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_wa] <= acc_wd;
        end
        acc_rd <= acc_mem[acc_ra];
    end

    // effective node count and helpers
    logic [CW-1:0]        w_n;
    logic                 w_last;
    logic [BDW-1:0]       w_base_num;
    logic [VW:0]          w_drem;
    logic [AW:0]          w_acc_sum;
    logic [RANK_BITS+AW:0] w_v;
    logic [RANK_BITS-1:0] w_x, w_diff;
    logic                 w_moved;
    logic [SW:0]          w_qrem;
    logic [SW-1:0]        w_sum_nx;
    logic [NW-1:0]        w_ef, w_et;

    always_comb begin
        if (r_node_count == '0) begin
            w_n = CW'(1);
        end else if (32'(r_node_count) > 32'(MAX_NODES)) begin
            w_n = CW'(MAX_NODES);
        end else begin
            w_n = CW'(r_node_count);
        end
    end

    assign w_last     = (r_i == w_n - CW'(1));
    assign w_base_num = (BDW'(17'h10000 - 17'(r_damp)) << FB) >> 16;
    assign w_drem     = {r_dr, r_dq[RANK_BITS-1]};
    assign w_acc_sum  = {1'b0, acc_rd} + (AW+1)'(r_dq);
    assign w_v        = (RANK_BITS+AW+1)'(r_base) + (RANK_BITS+AW+1)'(r_ph)
                      + (RANK_BITS+AW+1)'(r_pl >> 16);
    assign w_x        = (w_v > (RANK_BITS+AW+1)'({RANK_BITS{1'b1}})) ? '1 : RANK_BITS'(w_v);
    assign w_diff     = (r_old > w_x) ? (r_old - w_x) : (w_x - r_old);
    assign w_moved    = (64'(w_diff) > 64'(r_eps));
    assign w_qrem     = {r_qr, 1'b0};
    assign w_sum_nx   = r_sum + SW'(rank_rd);
    assign w_ef       = edge_rd[2*NW-1:NW];
    assign w_et       = edge_rd[NW-1:0];

    always_comb begin
        n_state = r_state;   n_ret = r_ret;     n_i = r_i;       n_e = r_e;
        n_edges = r_edges;   n_f = r_f;         n_t = r_t;       n_start = r_start;
        n_base = r_base;     n_dq = r_dq;       n_dr = r_dr;     n_dv = r_dv;
        n_cnt = r_cnt;       n_iter = r_iter;   n_more = r_more; n_ph = r_ph;
        n_pl = r_pl;         n_old = r_old;     n_sum = r_sum;   n_qr = r_qr;
        n_qq = r_qq;         n_res_rank = r_res_rank;   n_res_status = r_res_status;
        n_out_valid = r_out_valid;  n_out_rank = r_out_rank;
        n_out_iter = r_out_iter;    n_out_status = r_out_status;

        edge_we = 1'b0; edge_wa = EAW'(r_edges); edge_wd = '0; edge_ra = EAW'(r_e);
        deg_we = 1'b0;  deg_wa = r_f; deg_wd = deg_rd + ECW'(1); deg_ra = r_f;
        rank_we = 1'b0; rank_wa = NW'(r_i); rank_wd = w_x; rank_ra = NW'(r_i);
        acc_we = 1'b0;  acc_wa = NW'(r_i); acc_wd = '0; acc_ra = r_t;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                deg_we = 1'b1;
                deg_wa = NW'(r_i);
                deg_wd = '0;
                if (r_i == CW'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_IDLE: begin
                n_res_rank   = '0;
                n_res_status = pie_pkg::ST_OK;
                if (i_cmd.valid) begin
                    priority case (i_cmd.func)
                        pie_pkg::FUNC_ADD: begin
                            if (32'(i_cmd.edge_from) >= 32'(w_n) ||
                                32'(i_cmd.edge_to) >= 32'(w_n)) begin
                                n_res_status = pie_pkg::ST_BAD_ID;
                                n_state      = S_DONE;
                            end else if (32'(r_edges) >= 32'(MAX_EDGES)) begin
                                n_res_status = pie_pkg::ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                edge_we = 1'b1;
                                edge_wd = {NW'(i_cmd.edge_from), NW'(i_cmd.edge_to)};
                                deg_ra  = NW'(i_cmd.edge_from);
                                n_f     = NW'(i_cmd.edge_from);
                                n_state = S_ADD_WR;
                            end
                        end
                        pie_pkg::FUNC_RUN: begin
                            n_dq    = RANK_BITS'(1) << FB;
                            n_dr    = '0;
                            n_dv    = VW'(w_n);
                            n_cnt   = '0;
                            n_ret   = S_RUN_BASE;
                            n_state = S_DIV;
                        end
                        pie_pkg::FUNC_READ: begin
                            if (32'(i_cmd.read_node) >= 32'(w_n)) begin
                                n_res_status = pie_pkg::ST_BAD_ID;
                                n_state      = S_DONE;
                            end else begin
                                rank_ra = NW'(i_cmd.read_node);
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            // unused code: drop the beat
                        end
                    endcase
                end
            end
            S_ADD_WR: begin
                deg_we  = 1'b1;
                n_edges = r_edges + ECW'(1);
                n_state = S_DONE;
            end
            S_READ: begin
                n_res_rank = rank_rd;
                n_state    = S_DONE;
            end
            S_DIV: begin
                if (w_drem >= {1'b0, r_dv}) begin
                    n_dr = VW'(w_drem - {1'b0, r_dv});
                    n_dq = {r_dq[RANK_BITS-2:0], 1'b1};
                end else begin
                    n_dr = VW'(w_drem);
                    n_dq = {r_dq[RANK_BITS-2:0], 1'b0};
                end
                if (r_cnt == DCW'(RANK_BITS - 1)) begin
                    n_state = r_ret;
                end else begin
                    n_cnt = r_cnt + DCW'(1);
                end
            end
            S_RUN_BASE: begin
                n_start = r_dq;
                n_dq    = RANK_BITS'(w_base_num);
                n_dr    = '0;
                n_cnt   = '0;
                n_i     = '0;
                n_ret   = S_INIT;
                n_state = S_DIV;
            end
            S_INIT: begin
                n_base  = r_dq;
                rank_we = 1'b1;
                rank_wd = r_start;
                acc_we  = 1'b1;
                if (w_last) begin
                    n_iter = '0;
                    n_i    = '0;
                    if (r_max_iter == '0) begin
                        n_sum   = '0;
                        n_state = S_S_RD;
                    end else begin
                        n_e     = '0;
                        n_more  = 1'b0;
                        n_state = S_E_RD;
                    end
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_E_RD: begin
                if (r_e == r_edges) begin
                    n_i     = '0;
                    n_state = S_N_RD;
                end else begin
                    n_state = S_E_CHK;
                end
            end
            S_E_CHK: begin
                if (32'(w_ef) < 32'(w_n) && 32'(w_et) < 32'(w_n)) begin
                    rank_ra = w_ef;
                    deg_ra  = w_ef;
                    n_t     = w_et;
                    n_state = S_E_DIV;
                end else begin
                    n_e     = r_e + ECW'(1);
                    n_state = S_E_RD;
                end
            end
            S_E_DIV: begin
                if (deg_rd == '0) begin
                    n_e     = r_e + ECW'(1);
                    n_state = S_E_RD;
                end else begin
                    n_dq    = rank_rd;
                    n_dr    = '0;
                    n_dv    = VW'(deg_rd);
                    n_cnt   = '0;
                    n_ret   = S_E_ACC_RD;
                    n_state = S_DIV;
                end
            end
            S_E_ACC_RD: begin
                n_state = S_E_ACC_WR;
            end
            S_E_ACC_WR: begin
                acc_we  = 1'b1;
                acc_wa  = r_t;
                acc_wd  = w_acc_sum[AW] ? '1 : w_acc_sum[AW-1:0];
                n_e     = r_e + ECW'(1);
                n_state = S_E_RD;
            end
            S_N_RD: begin
                acc_ra  = NW'(r_i);
                n_state = S_N_MUL;
            end
            S_N_MUL: begin
                n_ph    = (AW-16)'(acc_rd[AW-1:16] * r_damp);
                n_pl    = acc_rd[15:0] * r_damp;
                n_old   = rank_rd;
                n_state = S_N_WR;
            end
            S_N_WR: begin
                rank_we = 1'b1;
                acc_we  = 1'b1;
                if (w_last) begin
                    n_iter = r_iter + pie_pkg::ITER_W'(1);
                    if (n_iter == r_max_iter || !(r_more || w_moved)) begin
                        n_i     = '0;
                        n_sum   = '0;
                        n_state = S_S_RD;
                    end else begin
                        n_e     = '0;
                        n_more  = 1'b0;
                        n_state = S_E_RD;
                    end
                end else begin
                    n_more  = r_more | w_moved;
                    n_i     = r_i + CW'(1);
                    n_state = S_N_RD;
                end
            end
            S_S_RD: begin
                n_state = S_S_ADD;
            end
            S_S_ADD: begin
                n_sum = w_sum_nx;
                if (w_last) begin
                    n_i     = '0;
                    n_state = (w_sum_nx == '0) ? S_DONE : S_Q_RD;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_S_RD;
                end
            end
            S_Q_RD: begin
                n_state = S_Q_INIT;
            end
            S_Q_INIT: begin
                if (SW'(rank_rd) >= r_sum) begin
                    n_qq = RANK_BITS'(1);
                    n_qr = SW'(rank_rd) - r_sum;
                end else begin
                    n_qq = '0;
                    n_qr = SW'(rank_rd);
                end
                n_cnt   = '0;
                n_state = S_Q_STEP;
            end
            S_Q_STEP: begin
                if (w_qrem >= {1'b0, r_sum}) begin
                    n_qr = SW'(w_qrem - {1'b0, r_sum});
                    n_qq = {r_qq[RANK_BITS-2:0], 1'b1};
                end else begin
                    n_qr = SW'(w_qrem);
                    n_qq = {r_qq[RANK_BITS-2:0], 1'b0};
                end
                if (r_cnt == DCW'(FB - 1)) begin
                    rank_we = 1'b1;
                    rank_wd = n_qq;
                    if (w_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_Q_RD;
                    end
                end else begin
                    n_cnt = r_cnt + DCW'(1);
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_rank   = pie_pkg::RANK_OUT_W'(r_res_rank);
                    n_out_iter   = r_iter;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_ret        <= S_IDLE;
            r_i          <= '0;
            r_e          <= '0;
            r_edges      <= '0;
            r_iter       <= '0;
            r_more       <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_node_count <= pie_pkg::NODE_COUNT_RST;
            r_max_iter   <= pie_pkg::MAX_ITER_RST;
            r_damp       <= pie_pkg::DAMPING_RST;
            r_eps        <= pie_pkg::EPSILON_RST;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_i         <= n_i;
            r_e         <= n_e;
            r_edges     <= n_edges;
            r_iter      <= n_iter;
            r_more      <= n_more;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pie_pkg::REG_NODE_COUNT: r_node_count <= i_cfg_data[pie_pkg::NCNT_W-1:0];
                    pie_pkg::REG_MAX_ITER:   r_max_iter   <= i_cfg_data[pie_pkg::ITER_W-1:0];
                    pie_pkg::REG_DAMPING:    r_damp       <= i_cfg_data[pie_pkg::DAMP_W-1:0];
                    pie_pkg::REG_EPSILON:    r_eps        <= i_cfg_data[pie_pkg::EPS_W-1:0];
                    default: ;
                endcase
            end
        end
        r_f          <= n_f;
        r_t          <= n_t;
        r_start      <= n_start;
        r_base       <= n_base;
        r_dq         <= n_dq;
        r_dr         <= n_dr;
        r_dv         <= n_dv;
        r_ph         <= n_ph;
        r_pl         <= n_pl;
        r_old        <= n_old;
        r_sum        <= n_sum;
        r_qr         <= n_qr;
        r_qq         <= n_qq;
        r_res_rank   <= n_res_rank;
        r_res_status <= n_res_status;
        r_out_rank   <= n_out_rank;
        r_out_iter   <= n_out_iter;
        r_out_status <= n_out_status;
    end

    assign i_cmd.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.rank_value      = r_out_rank;
    assign o_rsp.iterations_done = r_out_iter;
    assign o_rsp.status          = r_out_status;

endmodule

FILE: test/pie_checker.sv
`timescale 1ns / 1ps
module pie_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pie_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pie_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pie_cmd_if                             i_cmd,
    pie_rsp_if                             i_rsp,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_runs,
    output int                             o_reads,
    output int                             o_adds
);

    localparam int NODES = 1024;
    localparam int EDGES = 4096;
    localparam longint unsigned ONE      = 64'd1 << 31;
    localparam longint unsigned RANK_SAT = (64'd1 << 32) - 64'd1;
    localparam longint unsigned ACC_SAT  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [pie_pkg::RANK_OUT_W-1:0] rank;
        logic [pie_pkg::ITER_W-1:0]     iters;
        pie_pkg::t_status               status;
    } t_rank_beat;

    logic [pie_pkg::NCNT_W-1:0] cfg_nodes;
    logic [pie_pkg::ITER_W-1:0] max_iter;
    logic [pie_pkg::DAMP_W-1:0] damping;
    logic [pie_pkg::EPS_W-1:0]  epsilon;

    int unsigned       src_id [EDGES];
    int unsigned       dst_id [EDGES];
    int unsigned       edge_cnt;
    int unsigned       degree [NODES];
    longint unsigned   rank [NODES];
    longint unsigned   rank_nxt [NODES];
    longint unsigned   acc [NODES];
    logic [pie_pkg::ITER_W-1:0] pass_cnt;
    t_rank_beat        rank_q[$];

    function automatic int unsigned live_nodes();
        if (cfg_nodes == 0) return 1;
        if (cfg_nodes > NODES) return NODES;
        return 32'(cfg_nodes);
    endfunction

    function automatic longint unsigned frac_div(longint unsigned v, longint unsigned s);
        longint unsigned q, r;
        logic top;
        q = v / s;
        r = v % s;
        for (int i = 0; i < 31; i++) begin
            top = r[63];
            r = r << 1;
            q = q << 1;
            if (top || r >= s) begin
                r = r - s;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    task automatic power_iterate();
        int unsigned n;
        longint unsigned d, base, c, a, v, diff, sum;
        int unsigned f, t;
        logic more;
        n = live_nodes();
        d = 64'(damping);
        base = ((64'd65536 - d) * ONE) / (64'd65536 * n);
        for (int i = 0; i < n; i++) rank[i] = ONE / n;
        pass_cnt = '0;
        more = (max_iter != 0);
        while (more) begin
            for (int i = 0; i < NODES; i++) acc[i] = 0;
            for (int e = 0; e < edge_cnt; e++) begin
                f = src_id[e];
                t = dst_id[e];
                if (f >= n || t >= n || degree[f] == 0) continue;
                c = rank[f] / degree[f];
                acc[t] = (acc[t] > ACC_SAT - c) ? ACC_SAT : acc[t] + c;
            end
            for (int i = 0; i < n; i++) begin
                a = acc[i];
                v = base + (a >> 16) * d + (((a & 64'hFFFF) * d) >> 16);
                rank_nxt[i] = (v > RANK_SAT) ? RANK_SAT : v;
            end
            pass_cnt = pass_cnt + 1'b1;
            more = 1'b0;
            for (int i = 0; i < n; i++) begin
                diff = (rank[i] > rank_nxt[i]) ? rank[i] - rank_nxt[i] : rank_nxt[i] - rank[i];
                if (diff > 64'(epsilon)) more = 1'b1;
                rank[i] = rank_nxt[i];
            end
            if (pass_cnt == max_iter) more = 1'b0;
        end
        sum = 0;
        for (int i = 0; i < n; i++) sum += rank[i];
        if (sum != 0)
            for (int i = 0; i < n; i++) rank[i] = frac_div(rank[i], sum);
    endtask

    task automatic predict(pie_pkg::t_func fn, int unsigned from, int unsigned to,
                           int unsigned rn);
        t_rank_beat b;
        int unsigned n;
        n = live_nodes();
        b = '0;
        b.status = pie_pkg::ST_OK;
        if (fn == pie_pkg::FUNC_ADD) begin
            o_adds <= o_adds + 1;
            if (from >= n || to >= n) begin
                b.status = pie_pkg::ST_BAD_ID;
            end else if (edge_cnt >= EDGES) begin
                b.status = pie_pkg::ST_FULL;
            end else begin
                src_id[edge_cnt] = from;
                dst_id[edge_cnt] = to;
                edge_cnt++;
                degree[from]++;
            end
        end else if (fn == pie_pkg::FUNC_RUN) begin
            o_runs <= o_runs + 1;
            power_iterate();
        end else begin
            o_reads <= o_reads + 1;
            if (rn >= n) b.status = pie_pkg::ST_BAD_ID;
            else b.rank = rank[rn][31:0];
        end
        b.iters = pass_cnt;
        rank_q = {rank_q, b};
    endtask

    always @(posedge i_clk) begin
        t_rank_beat want;
        if (!i_rst_n) begin
            cfg_nodes  = pie_pkg::NODE_COUNT_RST;
            max_iter   = pie_pkg::MAX_ITER_RST;
            damping    = pie_pkg::DAMPING_RST;
            epsilon    = pie_pkg::EPSILON_RST;
            edge_cnt   = 0;
            pass_cnt   = '0;
            for (int i = 0; i < NODES; i++) begin
                degree[i] = 0;
                rank[i]   = 0;
            end
            rank_q.delete();
            o_fail_count <= 0;
            o_runs <= 0;
            o_reads <= 0;
            o_adds <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pie_pkg::REG_NODE_COUNT: cfg_nodes = i_cfg_data[pie_pkg::NCNT_W-1:0];
                    pie_pkg::REG_MAX_ITER:   max_iter  = i_cfg_data[pie_pkg::ITER_W-1:0];
                    pie_pkg::REG_DAMPING:    damping   = i_cfg_data[pie_pkg::DAMP_W-1:0];
                    pie_pkg::REG_EPSILON:    epsilon   = i_cfg_data[pie_pkg::EPS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready && i_cmd.func != pie_pkg::FUNC_NONE)
                predict(i_cmd.func, 32'(i_cmd.edge_from), 32'(i_cmd.edge_to),
                        32'(i_cmd.read_node));
            if (i_rsp.valid && i_rsp.ready) begin
                if (rank_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result beat rank=%h iters=%0d status=%0d",
                                 i_rsp.rank_value, i_rsp.iterations_done, i_rsp.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = rank_q.pop_front();
                    if (i_rsp.rank_value !== want.rank || i_rsp.iterations_done !== want.iters
                            || i_rsp.status !== want.status) begin
                        if (o_fail_count < 10)
                            $display("ERROR: rank/iters/status exp %h/%0d/%0d got %h/%0d/%0d",
                                     want.rank, want.iters, want.status, i_rsp.rank_value,
                                     i_rsp.iterations_done, i_rsp.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= rank_q.size();
    end
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int IDLE_LIMIT = 600000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [pie_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [pie_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count, pending, runs, reads, adds;

    pie_cmd_if cmd ();
    pie_rsp_if rsp ();

    pagerank_iteration_engine_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd),
        .o_rsp      (rsp)
    );

    pie_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_cmd        (cmd),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_runs       (runs),
        .o_reads      (reads),
        .o_adds       (adds)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    logic        cmd_fast, rsp_fast, hold_long;
    int unsigned node_lim, edges_held;
    logic        ranked [1024];

    // Watchdog: count cycles without any beat.
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side.
    initial begin
        int stall;
        rsp.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                rsp.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_long = 1'b0;
            end
            stall = rsp_fast ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                rsp.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp.ready = 1'b1;
            do @(posedge i_clk); while (!rsp.valid);
        end
    end

    function automatic int unsigned eff_nodes(int unsigned v);
        if (v == 0) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    task automatic cfg_write(pie_pkg::t_cfg_idx idx, logic [pie_pkg::CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == pie_pkg::REG_NODE_COUNT)
            node_lim = eff_nodes(32'(data[pie_pkg::NCNT_W-1:0]));
    endtask

    task automatic drain();
        cmd.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_cfg(int unsigned n, int unsigned iters, int unsigned d, int unsigned eps);
        drain();
        cfg_write(pie_pkg::REG_NODE_COUNT, n);
        cfg_write(pie_pkg::REG_MAX_ITER, iters);
        cfg_write(pie_pkg::REG_DAMPING, d);
        cfg_write(pie_pkg::REG_EPSILON, eps);
    endtask

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send(pie_pkg::t_func fn, int unsigned from, int unsigned to,
                        int unsigned rn);
        int gap;
        gap = cmd_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            cmd.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd.func = fn;
        cmd.edge_from = from[pie_pkg::ID_W-1:0];
        cmd.edge_to = to[pie_pkg::ID_W-1:0];
        cmd.read_node = rn[pie_pkg::ID_W-1:0];
        cmd.valid = 1'b1;
        do @(posedge i_clk); while (!cmd.ready);
        @(negedge i_clk);
        if (fn == pie_pkg::FUNC_ADD && from < node_lim && to < node_lim && edges_held < 4096)
            edges_held++;
        if (fn == pie_pkg::FUNC_RUN)
            for (int i = 0; i < node_lim; i++) ranked[i] = 1'b1;
    endtask

    task automatic send_read();
        int unsigned rn;
        rn = $urandom_range(0, 1023);
        if (rn < node_lim && !ranked[rn]) rn = (node_lim < 1024) ? node_lim : 0;
        if (rn < node_lim && !ranked[rn]) send(pie_pkg::FUNC_NONE, 0, 0, 0);
        else send(pie_pkg::FUNC_READ, $urandom, $urandom, rn);
    endtask

    task automatic random_item();
        int unsigned pick, from, to;
        pick = $urandom_range(0, 99);
        if (pick < 55 && (edges_held < 350 || node_lim < 1024)) begin
            if ($urandom_range(0, 9) == 0 || edges_held >= 350) begin
                from = $urandom_range(0, 1023);
                to = $urandom_range(0, 1023);
                if (edges_held >= 350) from = 1023;
            end else begin
                from = $urandom_range(0, node_lim - 1);
                to = $urandom_range(0, node_lim - 1);
            end
            send(pie_pkg::FUNC_ADD, from, to, $urandom);
        end else if (pick < 90) begin
            send_read();
        end else if (pick < 95) begin
            send(pie_pkg::FUNC_RUN, $urandom, $urandom, $urandom);
        end else begin
            send(pie_pkg::FUNC_NONE, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic random_cfg();
        int unsigned n, iters, d, eps;
        case ($urandom_range(0, 7))
            0: n = 0;
            1: n = 1;
            2: n = 1024;
            3: n = $urandom_range(1025, 2047);
            default: n = $urandom_range(2, 48);
        endcase
        case ($urandom_range(0, 3))
            0: d = 0;
            1: d = 65535;
            2: d = 32'(pie_pkg::DAMPING_RST);
            default: d = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 4))
            0: begin iters = 0; eps = $urandom; end
            // a huge limit only with a threshold that ends after one pass
            1: begin iters = 65535; eps = 32'hFFFF_FFFF; end
            2: begin iters = $urandom_range(1, 6); eps = 0; end
            default: begin iters = $urandom_range(1, 6); eps = $urandom_range(0, 1 << 20); end
        endcase
        set_cfg(n, iters, d, eps);
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.func = pie_pkg::FUNC_ADD;
        cmd.edge_from = '0;
        cmd.edge_to = '0;
        cmd.read_node = '0;
        cmd_fast = 1'b0;
        rsp_fast = 1'b0;
        hold_long = 1'b0;
        node_lim = 1024;
        edges_held = 0;
        for (int i = 0; i < 1024; i++) ranked[i] = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: small graph, bad ids, ignored func, extremes of the registers.
        set_cfg(4, 3, 32'(pie_pkg::DAMPING_RST), 0);
        send(pie_pkg::FUNC_ADD, 0, 1, 0);
        send(pie_pkg::FUNC_ADD, 1, 2, 0);
        send(pie_pkg::FUNC_ADD, 2, 0, 0);
        send(pie_pkg::FUNC_ADD, 3, 0, 0);
        send(pie_pkg::FUNC_ADD, 4, 1, 0);
        send(pie_pkg::FUNC_ADD, 1, 1023, 0);
        send(pie_pkg::FUNC_NONE, 1023, 1023, 1023);
        send(pie_pkg::FUNC_RUN, 0, 0, 0);
        send(pie_pkg::FUNC_READ, 0, 0, 0);
        send(pie_pkg::FUNC_READ, 0, 0, 3);
        send(pie_pkg::FUNC_READ, 0, 0, 1023);
        set_cfg(4, 0, 65535, 0);
        send(pie_pkg::FUNC_RUN, 0, 0, 0);
        send(pie_pkg::FUNC_READ, 0, 0, 2);
        set_cfg(4, 65535, 0, 32'hFFFF_FFFF);
        send(pie_pkg::FUNC_RUN, 0, 0, 0);
        send(pie_pkg::FUNC_READ, 0, 0, 1);
        // lower the node count below stored endpoints
        set_cfg(2, 4, 65535, 100);
        send(pie_pkg::FUNC_RUN, 0, 0, 0);
        send(pie_pkg::FUNC_READ, 0, 0, 1);
        send(pie_pkg::FUNC_READ, 0, 0, 2);
        set_cfg(0, 2, 1, 0);
        send(pie_pkg::FUNC_RUN, 0, 0, 0);
        send(pie_pkg::FUNC_READ, 0, 0, 0);

        for (int ph = 0; ph < 10; ph++) begin
            random_cfg();
            cmd_fast = ($urandom_range(0, 3) == 0);
            rsp_fast = ($urandom_range(0, 3) == 0);
            if (ph == 3) begin
                cmd_fast = 1'b1;
                hold_long = 1'b1;
                for (int k = 0; k < 40; k++) send(pie_pkg::FUNC_READ, 0, 0, 0);
                cmd_fast = 1'b0;
            end
            for (int k = 0; k < 50; k++) random_item();
            send(pie_pkg::FUNC_RUN, $urandom, $urandom, $urandom);
        end

        drain();
        repeat (20) @(negedge i_clk);
        $display("Covered %0d adds, %0d runs and %0d reads under random stalls,", adds, runs,
                 reads);
        $display("with node counts, damping, limits and thresholds at their extremes.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
